FILE: rtl/tlbflr_pkg.sv
// Package: shared types and constants of the age-ordered TLB.
`default_nettype none

package tlbflr_pkg;

  localparam int TLB_DEPTH_DEF   = 16;
  localparam int NUMBER_BITS_DEF = 20;

  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam int EIU_W      = 5;

  localparam logic [EIU_W-1:0] EIU_RESET = 5'd16;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_FLUSH  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REPLACEMENT_LRU = 1'b0,
    CFG_ENTRIES_IN_USE  = 1'b1
  } cfg_idx_t;

  // Where a cell takes its next contents from when it loads.
  typedef enum logic [1:0] {
    SRC_HOLD  = 2'd0,
    SRC_NEXT1 = 2'd1,
    SRC_NEXT2 = 2'd2,
    SRC_NEW   = 2'd3
  } src_t;

  typedef struct packed {
    logic load;
    src_t src;
    logic cmp_frame;
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/tlbflr_if.sv
// Interfaces: request and result channels of the TLB.
`default_nettype none

interface tlbflr_in_if #(
  parameter int NUMBER_BITS = tlbflr_pkg::NUMBER_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [tlbflr_pkg::KIND_W-1:0] kind;
  logic [NUMBER_BITS-1:0]        page;
  logic [NUMBER_BITS-1:0]        frame;

  modport source (output valid, kind, page, frame, input ready);
  modport sink   (input valid, kind, page, frame, output ready);
endinterface

interface tlbflr_out_if #(
  parameter int NUMBER_BITS = tlbflr_pkg::NUMBER_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic                   hit;
  logic [NUMBER_BITS-1:0] hit_frame;
  logic                   evicted;
  logic [NUMBER_BITS-1:0] evicted_page;
  logic [NUMBER_BITS-1:0] evicted_frame;

  modport source (output valid, hit, hit_frame, evicted, evicted_page, evicted_frame,
                  input ready);
  modport sink   (input valid, hit, hit_frame, evicted, evicted_page, evicted_frame,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/tlbflr_cell.sv
// One TLB slot: holds a page and frame, compares, and shifts toward the oldest end.
`default_nettype none

module tlbflr_cell #(
  parameter int NUMBER_BITS = tlbflr_pkg::NUMBER_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire tlbflr_pkg::cell_ctl_t  ctl,
  input  wire logic                   live,
  input  wire logic [NUMBER_BITS-1:0] key,
  input  wire logic                   ge_in,
  input  wire logic [NUMBER_BITS-1:0] next1_page,
  input  wire logic [NUMBER_BITS-1:0] next1_frame,
  input  wire logic [NUMBER_BITS-1:0] next2_page,
  input  wire logic [NUMBER_BITS-1:0] next2_frame,
  input  wire logic [NUMBER_BITS-1:0] new_page,
  input  wire logic [NUMBER_BITS-1:0] new_frame,
  output logic [NUMBER_BITS-1:0]      page,
  output logic [NUMBER_BITS-1:0]      frame,
  output logic                        ge_out,
  output logic                        first
);

  logic [NUMBER_BITS-1:0] page_r, page_nxt;
  logic [NUMBER_BITS-1:0] frame_r, frame_nxt;
  logic                   match;

  // Match against frame on insert, page on lookup; the prefix OR marks
  // this slot and every younger one once an older slot has matched.
  assign match  = live && ((ctl.cmp_frame ? frame_r : page_r) == key);
  assign ge_out = ge_in | match;
  assign first  = match & ~ge_in;

  always_comb begin
    page_nxt  = page_r;
    frame_nxt = frame_r;
    case (ctl.src)
      tlbflr_pkg::SRC_HOLD: begin
        page_nxt  = page_r;
        frame_nxt = frame_r;
      end
      tlbflr_pkg::SRC_NEXT1: begin
        page_nxt  = next1_page;
        frame_nxt = next1_frame;
      end
      tlbflr_pkg::SRC_NEXT2: begin
        page_nxt  = next2_page;
        frame_nxt = next2_frame;
      end
      tlbflr_pkg::SRC_NEW: begin
        page_nxt  = new_page;
        frame_nxt = new_frame;
      end
      default: begin
        page_nxt  = page_r;
        frame_nxt = frame_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      page_r  <= page_nxt;
      frame_r <= frame_nxt;
    end
  end

  assign page  = page_r;
  assign frame = frame_r;

endmodule

`default_nettype wire

FILE: rtl/tlb_fifo_lru_replacement_core.sv
// Top level: fully associative, age-ordered TLB with FIFO or LRU replacement.
//
// The TLB is a row of TLB_DEPTH cells, slot 0 the oldest. Every transaction
// is a lookup (kind 0), an insert (kind 1) or a flush (kind 2); kind 3 is
// answered with an all-zero result and changes nothing. Each accepted
// transaction yields exactly one result, which is then held in an output
// register; a new transaction is taken in every cycle in which that register
// is empty or being drained, so the sustained rate is one transaction per
// cycle. All cells compare their key in parallel, and a prefix OR that
// ripples from the oldest cell to the youngest picks the oldest match; the
// same cycle shifts younger entries one or two cells toward the oldest end
// and writes the new or promoted entry at the youngest live position. The
// ripple through TLB_DEPTH cells is the path that sets the clock. A lookup
// returns the frame of the oldest page match; with replacement_lru set the
// hit entry moves to the youngest slot. An insert first drops the oldest
// entry that holds the same frame, then evicts slot 0 if the live count is
// at or above capacity (entries_in_use, 0 read as 1, clamped to TLB_DEPTH),
// and appends the new entry. Configuration writes take effect at once and
// are meant for idle periods only. Entry storage has no reset: only slots
// below the live count are ever compared or read out.
`default_nettype none

module tlb_fifo_lru_replacement_core #(
  parameter int TLB_DEPTH   = tlbflr_pkg::TLB_DEPTH_DEF,
  parameter int NUMBER_BITS = tlbflr_pkg::NUMBER_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  tlbflr_in_if.sink                                in_ch,
  tlbflr_out_if.source                             out_ch,
  input  wire logic                                cfg_we,
  input  wire logic [tlbflr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tlbflr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW   = $clog2(TLB_DEPTH + 1);
  localparam int CMPW = (CW > tlbflr_pkg::EIU_W) ? CW : tlbflr_pkg::EIU_W;
  localparam int NB   = NUMBER_BITS;

  // Configuration registers.
  logic                         lru_r;
  logic [tlbflr_pkg::EIU_W-1:0] eiu_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lru_r <= 1'b0;
      eiu_r <= tlbflr_pkg::EIU_RESET;
    end else if (cfg_we) begin
      case (tlbflr_pkg::cfg_idx_t'(cfg_index))
        tlbflr_pkg::CFG_REPLACEMENT_LRU: lru_r <= cfg_data[0];
        tlbflr_pkg::CFG_ENTRIES_IN_USE:  eiu_r <= cfg_data[tlbflr_pkg::EIU_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Handshake: take a transaction whenever the result register frees up.
  logic out_valid_r;
  logic acc;

  assign in_ch.ready = ~out_valid_r | out_ch.ready;
  assign acc         = in_ch.valid & in_ch.ready;

  tlbflr_pkg::kind_t kind;
  logic is_lookup, is_insert, is_flush;

  assign kind      = tlbflr_pkg::kind_t'(in_ch.kind);
  assign is_lookup = (kind == tlbflr_pkg::KIND_LOOKUP);
  assign is_insert = (kind == tlbflr_pkg::KIND_INSERT);
  assign is_flush  = (kind == tlbflr_pkg::KIND_FLUSH);

  // Cell row wiring; two padding slots past the youngest cell read as zero.
  logic [NB-1:0]        pg   [0:TLB_DEPTH+1];
  logic [NB-1:0]        fr   [0:TLB_DEPTH+1];
  logic [TLB_DEPTH:0]   ge_chain;
  logic [TLB_DEPTH+1:1] ge_pad;
  logic [TLB_DEPTH-1:0] first;
  logic [TLB_DEPTH-1:0] live;
  tlbflr_pkg::cell_ctl_t ctl [0:TLB_DEPTH-1];

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NB-1:0] key;
  logic [NB-1:0] new_frame;

  assign pg[TLB_DEPTH]     = '0;
  assign fr[TLB_DEPTH]     = '0;
  assign pg[TLB_DEPTH+1]   = '0;
  assign fr[TLB_DEPTH+1]   = '0;
  assign ge_chain[0]       = 1'b0;
  assign ge_pad[TLB_DEPTH:1] = ge_chain[TLB_DEPTH:1];
  assign ge_pad[TLB_DEPTH+1] = ge_chain[TLB_DEPTH];

  assign key = is_insert ? in_ch.frame : in_ch.page;

  for (genvar g = 0; g < TLB_DEPTH; g++) begin : g_cell
    assign live[g] = (CW'(g) < cnt_r);

    tlbflr_cell #(
      .NUMBER_BITS (NUMBER_BITS)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl[g]),
      .live        (live[g]),
      .key         (key),
      .ge_in       (ge_chain[g]),
      .next1_page  (pg[g+1]),
      .next1_frame (fr[g+1]),
      .next2_page  (pg[g+2]),
      .next2_frame (fr[g+2]),
      .new_page    (in_ch.page),
      .new_frame   (new_frame),
      .page        (pg[g]),
      .frame       (fr[g]),
      .ge_out      (ge_chain[g+1]),
      .first       (first[g])
    );
  end

  // Oldest match: one-hot select of its frame.
  logic          found;
  logic [NB-1:0] match_frame;

  assign found = ge_chain[TLB_DEPTH];

  always_comb begin
    match_frame = '0;
    for (int i = 0; i < TLB_DEPTH; i++) begin
      match_frame = match_frame | ({NB{first[i]}} & fr[i]);
    end
  end

  // Capacity: 0 acts as 1, anything above the row length as the row length.
  logic [CMPW-1:0] eiu_ext, cap;

  assign eiu_ext = CMPW'(eiu_r);

  always_comb begin
    if (eiu_ext == '0) begin
      cap = CMPW'(1);
    end else if (eiu_ext > CMPW'(TLB_DEPTH)) begin
      cap = CMPW'(TLB_DEPTH);
    end else begin
      cap = eiu_ext;
    end
  end

  logic          found_ins, lru_hit, ev, modify;
  logic [CW-1:0] cnt_drop, np;

  assign found_ins = is_insert & found;
  assign lru_hit   = is_lookup & found & lru_r;
  assign cnt_drop  = cnt_r - CW'(found_ins);
  assign ev        = is_insert & (CMPW'(cnt_drop) >= cap);
  assign modify    = is_insert | lru_hit;
  // Youngest live slot after the update.
  assign np        = is_insert ? (cnt_drop - CW'(ev)) : (cnt_r - CW'(1));
  assign new_frame = is_insert ? in_ch.frame : match_frame;

  // Per-cell control: slots at or past the dropped entry close up by one,
  // and an eviction closes up everything by one more.
  always_comb begin
    for (int i = 0; i < TLB_DEPTH; i++) begin
      ctl[i].cmp_frame = is_insert;
      ctl[i].src       = tlbflr_pkg::SRC_HOLD;
      if (CW'(i) == np) begin
        ctl[i].src = tlbflr_pkg::SRC_NEW;
      end else if (CW'(i) < np) begin
        if (ev) begin
          ctl[i].src = (found_ins && ge_pad[i+2]) ? tlbflr_pkg::SRC_NEXT2
                                                  : tlbflr_pkg::SRC_NEXT1;
        end else if (ge_pad[i+1]) begin
          ctl[i].src = tlbflr_pkg::SRC_NEXT1;
        end
      end
      ctl[i].load = acc & modify & (ctl[i].src != tlbflr_pkg::SRC_HOLD);
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (acc) begin
      if (is_flush) begin
        cnt_nxt = '0;
      end else if (is_insert) begin
        cnt_nxt = np + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Result register: the entry leaving slot 0 is the post-drop oldest.
  logic          hit_r, evicted_r;
  logic [NB-1:0] hit_frame_r, ev_page_r, ev_frame_r;
  logic          hit_nxt, out_valid_nxt;
  logic [NB-1:0] hit_frame_nxt, ev_page_nxt, ev_frame_nxt;

  assign hit_nxt       = is_lookup & found;
  assign hit_frame_nxt = hit_nxt ? match_frame : '0;
  assign ev_page_nxt   = ev ? ((found_ins && first[0]) ? pg[1] : pg[0]) : '0;
  assign ev_frame_nxt  = ev ? ((found_ins && first[0]) ? fr[1] : fr[0]) : '0;
  assign out_valid_nxt = acc | (out_valid_r & ~out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      hit_r       <= hit_nxt;
      hit_frame_r <= hit_frame_nxt;
      evicted_r   <= ev;
      ev_page_r   <= ev_page_nxt;
      ev_frame_r  <= ev_frame_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.hit           = hit_r;
  assign out_ch.hit_frame     = hit_frame_r;
  assign out_ch.evicted       = evicted_r;
  assign out_ch.evicted_page  = ev_page_r;
  assign out_ch.evicted_frame = ev_frame_r;

  // Checks on the count and the result register.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(TLB_DEPTH))
    else $error("live count exceeds the row length");

  a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && is_flush) |=> (cnt_r == '0))
    else $error("flush left live entries");

  a_accept_shows: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid_r)
    else $error("accepted transaction produced no result");

  a_hit_excl_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && hit_r) |-> !evicted_r)
    else $error("result reports both hit and eviction");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && is_insert && !found_ins && !ev) |=> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("plain insert did not add one entry");

endmodule

`default_nettype wire
